// ----- rtl/core/world_to_screen_projection_top_assert.svh -----
// assertion macros for the world to screen projection block
// expects clk and rst_n in the scope of the module that uses them
`ifndef WORLD_TO_SCREEN_PROJECTION_TOP_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_TOP_ASSERT_SVH

// property must hold at every rising clock edge outside reset
`define WSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wsp property violated");

// condition must never be true outside reset
`define WSP_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("wsp forbidden condition");

`endif

// ----- rtl/core/wsp_pkg.sv -----
// shared types, widths and constants of the world to screen projection block
// no dependencies
package wsp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COEF_W = 32;
  localparam int POS_W = 32;
  localparam int PROD_W = COEF_W + POS_W;
  localparam int CLIP_W = PROD_W - FRAC_BITS + 2;
  localparam int SUM_W = CLIP_W + 1;
  localparam int DEN_W = CLIP_W + 1;
  localparam int VP_W = 16;
  localparam int NUM_W = SUM_W + VP_W;
  localparam int Q_W = 32;
  localparam int REM_W = DEN_W + 1;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES = Q_W / STEPS_PER_STAGE;
  localparam int LATENCY = 2 + 3 + DIV_STAGES + 1;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_DATA_W-1:0] RST_ROW_X_XY = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_W-1:0] RST_ROW_X_ZT = 64'h0;
  localparam logic [CFG_DATA_W-1:0] RST_ROW_Y_XY = 64'h0001_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_ROW_Y_ZT = 64'h0;
  localparam logic [CFG_DATA_W-1:0] RST_ROW_W_XY = 64'h0;
  localparam logic [CFG_DATA_W-1:0] RST_ROW_W_ZT = 64'h0001_0000_0000_0000;
  localparam logic [VP_W-1:0] RST_VP_WIDTH = 16'd1920;
  localparam logic [VP_W-1:0] RST_VP_HEIGHT = 16'd1080;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X_XY = 3'd0,
    REG_ROW_X_ZT = 3'd1,
    REG_ROW_Y_XY = 3'd2,
    REG_ROW_Y_ZT = 3'd3,
    REG_ROW_W_XY = 3'd4,
    REG_ROW_W_ZT = 3'd5,
    REG_VP_WIDTH = 3'd6,
    REG_VP_HEIGHT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0] pix_x;
    logic signed [Q_W-1:0] pix_y;
    logic                  w_zero;
  } out_item_t;

  typedef struct packed {
    logic                     valid;
    logic signed [CLIP_W-1:0] cx;
    logic signed [CLIP_W-1:0] cy;
    logic signed [CLIP_W-1:0] cw;
  } clip_t;

  typedef struct packed {
    logic                  valid;
    logic                  w_zero;
    logic signed [Q_W-1:0] coord;
  } lane_out_t;

endpackage

// ----- rtl/core/wsp_xform.sv -----
// matrix stage: nine products, then floor shift and row sums to clip x, y, w
// depends on wsp_pkg
module wsp_xform
  import wsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  in_item_t              in_data,
  input  logic [CFG_DATA_W-1:0] row_x_xy,
  input  logic [CFG_DATA_W-1:0] row_x_zt,
  input  logic [CFG_DATA_W-1:0] row_y_xy,
  input  logic [CFG_DATA_W-1:0] row_y_zt,
  input  logic [CFG_DATA_W-1:0] row_w_xy,
  input  logic [CFG_DATA_W-1:0] row_w_zt,
  output clip_t                 clip
);

  logic                     p_valid_r;
  logic signed [PROD_W-1:0] prod_r [9];
  logic signed [PROD_W-1:0] prod_nxt [9];
  logic signed [COEF_W-1:0] trans_r [3];
  logic signed [COEF_W-1:0] coef [9];
  logic signed [CLIP_W-1:0] sum_nxt [3];
  logic                     c_valid_r;
  logic signed [CLIP_W-1:0] c_r [3];

  always_comb begin
    coef[0] = $signed(row_x_xy[COEF_W-1:0]);
    coef[1] = $signed(row_x_xy[2*COEF_W-1:COEF_W]);
    coef[2] = $signed(row_x_zt[COEF_W-1:0]);
    coef[3] = $signed(row_y_xy[COEF_W-1:0]);
    coef[4] = $signed(row_y_xy[2*COEF_W-1:COEF_W]);
    coef[5] = $signed(row_y_zt[COEF_W-1:0]);
    coef[6] = $signed(row_w_xy[COEF_W-1:0]);
    coef[7] = $signed(row_w_xy[2*COEF_W-1:COEF_W]);
    coef[8] = $signed(row_w_zt[COEF_W-1:0]);
    for (int r = 0; r < 3; r++) begin
      prod_nxt[3*r]   = PROD_W'(coef[3*r])   * PROD_W'(in_data.pos_x);
      prod_nxt[3*r+1] = PROD_W'(coef[3*r+1]) * PROD_W'(in_data.pos_y);
      prod_nxt[3*r+2] = PROD_W'(coef[3*r+2]) * PROD_W'(in_data.pos_z);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      prod_r[i] <= prod_nxt[i];
    end
    trans_r[0] <= $signed(row_x_zt[2*COEF_W-1:COEF_W]);
    trans_r[1] <= $signed(row_y_zt[2*COEF_W-1:COEF_W]);
    trans_r[2] <= $signed(row_w_zt[2*COEF_W-1:COEF_W]);
  end

  // arithmetic shift is the floor of the rescaled product
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_nxt[r] = CLIP_W'(prod_r[3*r] >>> FRAC_BITS)
                 + CLIP_W'(prod_r[3*r+1] >>> FRAC_BITS)
                 + CLIP_W'(prod_r[3*r+2] >>> FRAC_BITS)
                 + CLIP_W'(trans_r[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      c_r[r] <= sum_nxt[r];
    end
  end

  assign clip.valid = c_valid_r;
  assign clip.cx = c_r[0];
  assign clip.cy = c_r[1];
  assign clip.cw = c_r[2];

endmodule

// ----- rtl/core/wsp_lane.sv -----
// one screen coordinate: (c + w) * vp / (2w) with pipelined restoring divide
// and saturation; depends on wsp_pkg
module wsp_lane
  import wsp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic signed [CLIP_W-1:0] c,
  input  logic signed [CLIP_W-1:0] w,
  input  logic [VP_W-1:0]          vp,
  output lane_out_t                res
);

  // stage a: magnitudes and signs
  logic signed [SUM_W-1:0] s;
  logic [SUM_W-1:0]        sm_nxt;
  logic [CLIP_W-1:0]       wm;
  logic                    a_valid_r, a_neg_r, a_zero_r;
  logic [SUM_W-1:0]        a_sm_r;
  logic [DEN_W-1:0]        a_den_r;
  logic [VP_W-1:0]         a_vp_r;

  always_comb begin
    s = SUM_W'(c) + SUM_W'(w);
    sm_nxt = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    wm = w[CLIP_W-1] ? CLIP_W'(-w) : CLIP_W'(w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_neg_r <= s[SUM_W-1] ^ w[CLIP_W-1];
    a_zero_r <= (w == '0);
    a_sm_r <= sm_nxt;
    a_den_r <= {wm, 1'b0};
    a_vp_r <= vp;
  end

  // stage b: numerator product
  logic             b_valid_r, b_neg_r, b_zero_r;
  logic [NUM_W-1:0] b_num_r;
  logic [DEN_W-1:0] b_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    b_neg_r <= a_neg_r;
    b_zero_r <= a_zero_r;
    b_num_r <= NUM_W'(a_sm_r) * NUM_W'(a_vp_r);
    b_den_r <= a_den_r;
  end

  // divider pipeline, entry 0 is the prepared item
  logic             d_valid_r [DIV_STAGES+1];
  logic             d_neg_r   [DIV_STAGES+1];
  logic             d_zero_r  [DIV_STAGES+1];
  logic             d_ovf_r   [DIV_STAGES+1];
  logic [REM_W-1:0] d_rem_r   [DIV_STAGES+1];
  logic [Q_W-1:0]   d_lo_r    [DIV_STAGES+1];
  logic [Q_W-1:0]   d_q_r     [DIV_STAGES+1];
  logic [DEN_W-1:0] d_den_r   [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r[0] <= 1'b0;
    end else begin
      d_valid_r[0] <= b_valid_r;
    end
  end

  // quotient of 2^Q_W or more saturates
  always_ff @(posedge clk) begin
    d_neg_r[0] <= b_neg_r;
    d_zero_r[0] <= b_zero_r;
    d_ovf_r[0] <= DEN_W'(b_num_r[NUM_W-1:Q_W]) >= b_den_r;
    d_rem_r[0] <= REM_W'(b_num_r[NUM_W-1:Q_W]);
    d_lo_r[0] <= b_num_r[Q_W-1:0];
    d_q_r[0] <= '0;
    d_den_r[0] <= b_den_r;
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    logic [REM_W-1:0] rem_nxt;
    logic [Q_W-1:0]   lo_nxt;
    logic [Q_W-1:0]   q_nxt;

    always_comb begin
      rem_nxt = d_rem_r[g];
      lo_nxt = d_lo_r[g];
      q_nxt = d_q_r[g];
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        rem_nxt = {rem_nxt[REM_W-2:0], lo_nxt[Q_W-1]};
        lo_nxt = {lo_nxt[Q_W-2:0], 1'b0};
        if (rem_nxt >= REM_W'(d_den_r[g])) begin
          rem_nxt = rem_nxt - REM_W'(d_den_r[g]);
          q_nxt = {q_nxt[Q_W-2:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_valid_r[g+1] <= 1'b0;
      end else begin
        d_valid_r[g+1] <= d_valid_r[g];
      end
    end

    always_ff @(posedge clk) begin
      d_neg_r[g+1] <= d_neg_r[g];
      d_zero_r[g+1] <= d_zero_r[g];
      d_ovf_r[g+1] <= d_ovf_r[g];
      d_rem_r[g+1] <= rem_nxt;
      d_lo_r[g+1] <= lo_nxt;
      d_q_r[g+1] <= q_nxt;
      d_den_r[g+1] <= d_den_r[g];
    end
  end

  // sign, saturation and the zero w case
  localparam logic [Q_W-1:0] MAX_POS = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] MIN_NEG = {1'b1, {(Q_W-1){1'b0}}};

  logic [Q_W-1:0]        qf;
  logic signed [Q_W-1:0] coord_nxt;
  logic                  o_valid_r, o_zero_r;
  logic signed [Q_W-1:0] o_coord_r;

  always_comb begin
    qf = d_q_r[DIV_STAGES];
    if (d_zero_r[DIV_STAGES]) begin
      coord_nxt = '0;
    end else if (d_neg_r[DIV_STAGES]) begin
      coord_nxt = (d_ovf_r[DIV_STAGES] || qf > MIN_NEG) ? MIN_NEG : -qf;
    end else begin
      coord_nxt = (d_ovf_r[DIV_STAGES] || qf > MAX_POS) ? MAX_POS : qf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= d_valid_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    o_zero_r <= d_zero_r[DIV_STAGES];
    o_coord_r <= coord_nxt;
  end

  assign res.valid = o_valid_r;
  assign res.w_zero = o_zero_r;
  assign res.coord = o_coord_r;

endmodule

// ----- rtl/core/world_to_screen_projection_top.sv -----
// path: matrix product and clip registers, lane stages a and b, divider entry and stages, output register
// throughput: one item per cycle, busy stays low; every stage is a plain pipeline register
// reset: synchronous active-low rst_n clears all valid bits and loads the
// identity rows and a 1920 x 1080 viewport; the receiver cannot stall
// top level: config registers, matrix stage and two divide lanes
// depends on wsp_pkg, wsp_xform, wsp_lane and the assertion header
`include "world_to_screen_projection_top_assert.svh"

module world_to_screen_projection_top
  import wsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CFG_DATA_W-1:0] row_x_xy_r, row_x_zt_r, row_y_xy_r;
  logic [CFG_DATA_W-1:0] row_y_zt_r, row_w_xy_r, row_w_zt_r;
  logic [VP_W-1:0]       vp_width_r, vp_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_xy_r <= RST_ROW_X_XY;
      row_x_zt_r <= RST_ROW_X_ZT;
      row_y_xy_r <= RST_ROW_Y_XY;
      row_y_zt_r <= RST_ROW_Y_ZT;
      row_w_xy_r <= RST_ROW_W_XY;
      row_w_zt_r <= RST_ROW_W_ZT;
      vp_width_r <= RST_VP_WIDTH;
      vp_height_r <= RST_VP_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_ROW_X_XY: row_x_xy_r <= cfg_wdata;
        REG_ROW_X_ZT: row_x_zt_r <= cfg_wdata;
        REG_ROW_Y_XY: row_y_xy_r <= cfg_wdata;
        REG_ROW_Y_ZT: row_y_zt_r <= cfg_wdata;
        REG_ROW_W_XY: row_w_xy_r <= cfg_wdata;
        REG_ROW_W_ZT: row_w_zt_r <= cfg_wdata;
        REG_VP_WIDTH: vp_width_r <= cfg_wdata[VP_W-1:0];
        REG_VP_HEIGHT: vp_height_r <= cfg_wdata[VP_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  clip_t     clip;
  lane_out_t lane_x, lane_y;

  wsp_xform u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_data  (in_data),
    .row_x_xy (row_x_xy_r),
    .row_x_zt (row_x_zt_r),
    .row_y_xy (row_y_xy_r),
    .row_y_zt (row_y_zt_r),
    .row_w_xy (row_w_xy_r),
    .row_w_zt (row_w_zt_r),
    .clip     (clip)
  );

  wsp_lane u_lane_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (clip.valid),
    .c        (clip.cx),
    .w        (clip.cw),
    .vp       (vp_width_r),
    .res      (lane_x)
  );

  wsp_lane u_lane_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (clip.valid),
    .c        (clip.cy),
    .w        (clip.cw),
    .vp       (vp_height_r),
    .res      (lane_y)
  );

  assign out_valid = lane_x.valid;
  assign out_data.pix_x = lane_x.coord;
  assign out_data.pix_y = lane_y.coord;
  assign out_data.w_zero = lane_x.w_zero;

  `WSP_ASSERT(a_latency, start |-> ##LATENCY out_valid)
  `WSP_NEVER(a_w0_origin, out_valid && out_data.w_zero && (out_data.pix_x | out_data.pix_y) != '0)
  `WSP_NEVER(a_lanes_aligned, lane_x.valid != lane_y.valid || (lane_x.valid && lane_x.w_zero != lane_y.w_zero))

endmodule
